@@ rtl/bfip_pkg.sv @@
// ----------------------------------------------------------------------------
// bfip_pkg
// Shared types, constants and helpers for the bloom filter insert/probe block.
// ----------------------------------------------------------------------------
package bfip_pkg;

  localparam int MAX_SIZE_LOG2 = 21;
  localparam int MIN_SIZE_LOG2 = 6;
  localparam int MAX_PROBES    = 8;
  localparam int BIT_IDX_W     = 6;
  localparam int WORD_W        = 1 << BIT_IDX_W;
  localparam int ADDR_W        = MAX_SIZE_LOG2 - BIT_IDX_W;
  localparam int PROBE_CNT_W   = $clog2(MAX_PROBES + 1);

  localparam int HASH_W        = 32;
  localparam int SIZE_W        = 5;
  localparam int PCOUNT_W      = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_PROBE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_PRESENT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } pos_ctl_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s < SIZE_W'(MIN_SIZE_LOG2)) begin
      r = SIZE_W'(MIN_SIZE_LOG2);
    end else if (s > SIZE_W'(MAX_SIZE_LOG2)) begin
      r = SIZE_W'(MAX_SIZE_LOG2);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // word-index mask: keeps the low (size - 6) bits of the word index
  function automatic logic [ADDR_W-1:0] word_mask(input logic [SIZE_W-1:0] s);
    logic [ADDR_W-1:0] m;
    logic [SIZE_W-1:0] es;
    es = eff_size(s);
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (SIZE_W'(i + BIT_IDX_W) < es);
    end
    return m;
  endfunction

  function automatic logic [PROBE_CNT_W-1:0] eff_probes(input logic [PCOUNT_W-1:0] k);
    logic [PROBE_CNT_W-1:0] r;
    if (k > PCOUNT_W'(MAX_PROBES)) begin
      r = PROBE_CNT_W'(MAX_PROBES);
    end else begin
      r = PROBE_CNT_W'(k);
    end
    return r;
  endfunction

endpackage

@@ rtl/bfip_pos_gen.sv @@
// ----------------------------------------------------------------------------
// bfip_pos_gen
// Double-hashing position generator: one shared 32-bit adder steps h1 + j*h2.
// ----------------------------------------------------------------------------
module bfip_pos_gen (
  input  logic                                clk,
  input  bfip_pkg::pos_ctl_t                  ctl,
  input  logic [bfip_pkg::HASH_W-1:0]         hash,
  input  logic [bfip_pkg::SIZE_W-1:0]         size_log2,
  output logic [bfip_pkg::ADDR_W-1:0]         word_addr,
  output logic [bfip_pkg::BIT_IDX_W-1:0]      bit_idx
);
  import bfip_pkg::*;

  logic [HASH_W-1:0] pos;
  logic [HASH_W-1:0] step;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos  <= hash;
      step <= {hash[HASH_W/2-1:0], hash[HASH_W-1:HASH_W/2]} | HASH_W'(1);
    end else if (ctl.advance) begin
      pos  <= pos + step;
    end
  end

  assign word_addr = pos[BIT_IDX_W +: ADDR_W] & word_mask(size_log2);
  assign bit_idx   = pos[BIT_IDX_W-1:0];

endmodule

@@ rtl/bfip_bit_mem.sv @@
// ----------------------------------------------------------------------------
// bfip_bit_mem
// Single-port filter word memory with registered read data.
// ----------------------------------------------------------------------------
module bfip_bit_mem (
  input  logic                        clk,
  input  bfip_pkg::mem_req_t          req,
  output logic [bfip_pkg::WORD_W-1:0] rdata
);
  import bfip_pkg::*;

  logic [WORD_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

@@ rtl/bloom_filter_insert_probe.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_probe
// Bloom filter with double hashing: clear, insert and probe commands.
// ----------------------------------------------------------------------------
// The filter lives in one single-port memory of 32768 words of 64 bits, and
// one position adder walks the k positions of a hash. Each position takes a
// memory read, then a check or read-modify-write; after the last one an insert
// returns to idle and a probe moves to its answer state to post its answer
// (k is 6 by default); a probe stops at the first clear bit it meets, so a
// definite miss frees the block sooner. A probe with no filter present or with
// k of zero goes straight to its answer state, and such an insert returns to
// idle without a walk. A clear command sweeps the whole memory, one word a
// cycle; the same sweep runs after reset, and in_stall stays high during it
// while configuration writes are still taken.
// The answer sits in an output register, so the next word can be accepted
// while an answer waits to be taken; a probe that finishes while that answer
// is still stalled holds in its answer state until the answer is taken.
// ----------------------------------------------------------------------------
module bloom_filter_insert_probe (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic [bfip_pkg::HASH_W-1:0]     hash,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            may_be_present,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfip_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfip_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [SIZE_W-1:0]       size_log2;
  logic [PCOUNT_W-1:0]     probe_count;
  logic                    filter_present;
  logic [PROBE_CNT_W-1:0]  left;
  logic                    is_insert;
  logic                    ans;
  logic [ADDR_W-1:0]       clr_addr;

  pos_ctl_t                pos_ctl;
  mem_req_t                mem_req;
  logic [ADDR_W-1:0]       word_addr;
  logic [BIT_IDX_W-1:0]    bit_idx;
  logic [WORD_W-1:0]       rdata;
  logic                    cur_bit;
  logic                    in_accept;
  logic                    out_load;
  logic                    walk;
  logic [PROBE_CNT_W-1:0]  k_eff;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign k_eff     = eff_probes(probe_count);
  assign walk      = filter_present && (k_eff != '0);
  assign cur_bit   = rdata[bit_idx];

  bfip_pos_gen u_pos_gen (
    .clk       (clk),
    .ctl       (pos_ctl),
    .hash      (hash),
    .size_log2 (size_log2),
    .word_addr (word_addr),
    .bit_idx   (bit_idx)
  );

  bfip_bit_mem u_bit_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (command)
            CMD_CLEAR:  state_next = ST_CLEAR;
            CMD_INSERT: state_next = walk ? ST_READ : ST_IDLE;
            CMD_PROBE:  state_next = walk ? ST_READ : ST_RESP;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (is_insert) begin
          state_next = (left == PROBE_CNT_W'(1)) ? ST_IDLE : ST_READ;
        end else if (!cur_bit || left == PROBE_CNT_W'(1)) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_RESP: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall        = 1'b1;
    pos_ctl.load    = 1'b0;
    pos_ctl.advance = 1'b0;
    mem_req.we      = 1'b0;
    mem_req.addr    = word_addr;
    mem_req.wdata   = rdata | (WORD_W'(1) << bit_idx);
    out_load        = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr;
        mem_req.wdata = '0;
      end
      ST_IDLE: begin
        in_stall     = 1'b0;
        pos_ctl.load = in_accept;
      end
      ST_READ: ;
      ST_CHECK: begin
        mem_req.we      = is_insert;
        pos_ctl.advance = 1'b1;
      end
      ST_RESP: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      size_log2      <= SIZE_W'(6);
      probe_count    <= PCOUNT_W'(6);
      filter_present <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_LOG2:      size_log2      <= cfg_data[SIZE_W-1:0];
          REG_PROBE_COUNT:    probe_count    <= cfg_data[PCOUNT_W-1:0];
          REG_FILTER_PRESENT: filter_present <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end else if (in_accept && command == CMD_CLEAR) begin
        clr_addr <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the walk and the answer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      left      <= k_eff;
      is_insert <= (command == CMD_INSERT);
      ans       <= 1'b1;
    end else if (state == ST_CHECK) begin
      left <= left - PROBE_CNT_W'(1);
      if (!is_insert && !cur_bit) ans <= 1'b0;
    end
    if (out_load) may_be_present <= ans;
  end

  // memory is written only by the clear sweep or an insert update
  assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_CLEAR) || (state == ST_CHECK && is_insert))
    else $error("filter memory written outside clear or insert");

  // the walk never runs with no positions left
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_CHECK) |-> left != '0)
    else $error("position walk with zero count");

  // a probe with no filter answers may-be-present right away
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_PROBE && !filter_present) |=> (state == ST_RESP) && ans)
    else $error("probe without filter did not answer one");

  // a clear bit seen by a probe ends the walk with a zero answer
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && !is_insert && !cur_bit) |=> (state == ST_RESP) && !ans)
    else $error("clear bit did not end the probe with zero");

endmodule

@@ verif/bloom_filter_insert_probe_tb.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_probe_tb
// Self-checking bench for the bloom filter insert/probe block. A queue-fed
// driver sends clear, insert, probe and unused command words with random gaps.
// A monitor takes probe answers under random stalls and checks them against an
// in-bench copy of the bit array. The filter settings change between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module bloom_filter_insert_probe_tb;
  import bfip_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int WORD_COUNT     = 1 << ADDR_W;
  localparam int INSERT_SETTLE  = 40;     // covers the longest insert (k of 8)
  localparam int CLEAR_SETTLE   = 32800;  // covers a full clear sweep
  localparam int WATCHDOG_LIMIT = 150000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_WORDS    = 125;

  typedef struct {
    cmd_t              command;
    logic [HASH_W-1:0] hash;
  } filter_cmd_t;

  typedef struct {
    logic [HASH_W-1:0] hash;
    logic              present;
  } probe_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            command = CMD_CLEAR;
  logic [HASH_W-1:0]     hash = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  may_be_present;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bloom_filter_insert_probe uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .hash           (hash),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .may_be_present (may_be_present),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  // bench copy of the filter and its settings
  bit   [WORD_W-1:0]   filter_words [WORD_COUNT];
  logic [SIZE_W-1:0]   set_size = 5'd6;
  logic [PCOUNT_W-1:0] set_probes = 4'd6;
  logic                set_present = 1'b1;

  filter_cmd_t   pending_words [$];
  probe_answer_t expected_answers [$];
  filter_cmd_t   cur_word;
  logic [HASH_W-1:0] inserted_hashes [$];

  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned answers_checked = 0;
  int unsigned clears_sent = 0;
  int unsigned settings_used = 0;
  int unsigned failures = 0;
  int unsigned in_gap_max = 0;
  int unsigned out_stall_max = 0;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          last_was_clear = 1'b0;

  // walk the k double-hash positions; insert sets them, probe tests them; clear wipes the copy
  function automatic void run_filter_cmd(input filter_cmd_t cmd_word);
    int                unsigned eff_log2;
    int                unsigned k;
    logic [HASH_W-1:0] step;
    logic [HASH_W-1:0] mask;
    logic [HASH_W-1:0] pos;
    logic              all_set;
    eff_log2 = (set_size < MIN_SIZE_LOG2) ? MIN_SIZE_LOG2 :
               (set_size > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : set_size;
    k = (set_probes > MAX_PROBES) ? MAX_PROBES : set_probes;
    mask = (32'd1 << eff_log2) - 32'd1;
    step = {cmd_word.hash[15:0], cmd_word.hash[31:16]} | 32'd1;
    all_set = 1'b1;
    case (cmd_word.command)
      CMD_CLEAR: begin
        foreach (filter_words[i]) filter_words[i] = '0;
      end
      CMD_INSERT: begin
        if (set_present) begin
          for (int unsigned j = 0; j < k; j++) begin
            pos = (cmd_word.hash + step * HASH_W'(j)) & mask;
            filter_words[pos[MAX_SIZE_LOG2-1:BIT_IDX_W]][pos[BIT_IDX_W-1:0]] = 1'b1;
          end
        end
      end
      CMD_PROBE: begin
        if (set_present) begin
          for (int unsigned j = 0; j < k; j++) begin
            pos = (cmd_word.hash + step * HASH_W'(j)) & mask;
            if (!filter_words[pos[MAX_SIZE_LOG2-1:BIT_IDX_W]][pos[BIT_IDX_W-1:0]])
              all_set = 1'b0;
          end
        end
        expected_answers.push_back('{hash: cmd_word.hash, present: all_set});
      end
      default: ;
    endcase
  endfunction

  // driver: payload holds while stalled, gap drawn after each accepted word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        run_filter_cmd(cur_word);
        words_accepted++;
        in_gap_left = $urandom_range(0, in_gap_max);
      end
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        command  <= cur_word.command;
        hash     <= cur_word.hash;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: stall count drawn per answer, counted down while an answer waits
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected answer, expected none, actual %b", $time, may_be_present);
          failures++;
        end else begin
          probe_answer_t exp_ans;
          exp_ans = expected_answers.pop_front();
          if (may_be_present !== exp_ans.present) begin
            $display("%0t: answer mismatch for hash %h: expected %b, actual %b",
                     $time, exp_ans.hash, exp_ans.present, may_be_present);
            failures++;
          end
          answers_checked++;
        end
        out_stall_left = $urandom_range(0, out_stall_max);
      end else if (out_valid && out_stall_left > 0) begin
        out_stall_left--;
      end
      out_stall <= (out_stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(input cmd_t cmd, input logic [HASH_W-1:0] h);
    pending_words.push_back('{command: cmd, hash: h});
    words_queued++;
    last_was_clear = (cmd == CMD_CLEAR);
    if (cmd == CMD_CLEAR) begin
      clears_sent++;
      inserted_hashes.delete();
    end else if (cmd == CMD_INSERT) begin
      inserted_hashes.push_back(h);
    end
  endtask

  // wait for all answers, then let an insert or a clear sweep finish
  task automatic drain_and_settle();
    while (words_accepted != words_queued || expected_answers.size() != 0)
      @(posedge clk);
    repeat (last_was_clear ? CLEAR_SETTLE : INSERT_SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes never toggle it in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SIZE_LOG2:      set_size = val;
      REG_PROBE_COUNT:    set_probes = val[PCOUNT_W-1:0];
      REG_FILTER_PRESENT: set_present = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned sz, input int unsigned k, input bit pres);
    write_reg(REG_SIZE_LOG2, CFG_DATA_W'(sz));
    write_reg(REG_PROBE_COUNT, {1'($urandom), PCOUNT_W'(k)});
    write_reg(REG_FILTER_PRESENT, {4'($urandom), pres});
    cfg_valid <= 1'b0;
    settings_used++;
    in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
    out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
  endtask

  task automatic queue_random_word();
    int unsigned       r;
    logic [HASH_W-1:0] h;
    r = $urandom_range(0, 999);
    if (r < 3) begin
      queue_word(CMD_CLEAR, $urandom());
    end else if (r < 15) begin
      queue_word(CMD_UNUSED, $urandom());
    end else if (r < 450) begin
      queue_word(CMD_INSERT, $urandom());
    end else begin
      h = $urandom();
      if (inserted_hashes.size() > 0 && r < 800) begin
        h = inserted_hashes[$urandom_range(0, inserted_hashes.size() - 1)];
        // near miss: one bit away from a stored hash
        if (r >= 700) h = h ^ (32'd1 << $urandom_range(0, 31));
      end
      queue_word(CMD_PROBE, h);
    end
  endtask

  initial begin
    int unsigned sz;
    int unsigned k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // defaults, basic insert and probe, hash extremes, unused command
    apply_settings(6, 6, 1'b1);
    queue_word(CMD_PROBE, 32'h0000_0000);
    queue_word(CMD_INSERT, 32'h0000_0000);
    queue_word(CMD_PROBE, 32'h0000_0000);
    queue_word(CMD_INSERT, 32'hFFFF_FFFF);
    queue_word(CMD_PROBE, 32'hFFFF_FFFF);
    queue_word(CMD_PROBE, 32'h0000_FFFF);
    queue_word(CMD_INSERT, 32'hFFFF_0000);
    queue_word(CMD_PROBE, 32'hFFFF_0000);
    queue_word(CMD_UNUSED, 32'h5A5A_5A5A);
    queue_word(CMD_PROBE, 32'h1234_5678);
    drain_and_settle();

    // size below range, zero probes
    apply_settings(0, 0, 1'b1);
    queue_word(CMD_INSERT, 32'hA5A5_A5A5);
    queue_word(CMD_PROBE, 32'h89AB_CDEF);
    drain_and_settle();

    // size above range, probe count above range
    apply_settings(31, 15, 1'b1);
    queue_word(CMD_INSERT, 32'h0000_0001);
    queue_word(CMD_PROBE, 32'h0000_0001);
    queue_word(CMD_PROBE, 32'h0001_0000);
    drain_and_settle();

    // no filter: insert ignored, probe says maybe, clear still wipes
    apply_settings(21, 8, 1'b0);
    queue_word(CMD_INSERT, 32'hDEAD_BEEF);
    queue_word(CMD_PROBE, 32'h0BAD_F00D);
    queue_word(CMD_CLEAR, 32'hFFFF_FFFF);
    drain_and_settle();

    apply_settings(21, 8, 1'b1);
    queue_word(CMD_PROBE, 32'h0000_0001);
    queue_word(CMD_INSERT, 32'h1357_9BDF);
    drain_and_settle();

    // shrink without clear: old bits stay, positions masked to the new size
    write_reg(REG_NONE, 5'h1F);
    apply_settings(6, 1, 1'b1);
    queue_word(CMD_PROBE, 32'h1357_9BDF);
    queue_word(CMD_INSERT, 32'hCAFE_F00D);
    queue_word(CMD_PROBE, 32'h0000_0000);
    drain_and_settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       sz = $urandom_range(0, 5);
        1:       sz = MIN_SIZE_LOG2;
        2:       sz = MAX_SIZE_LOG2;
        3:       sz = $urandom_range(MAX_SIZE_LOG2 + 1, 31);
        default: sz = $urandom_range(MIN_SIZE_LOG2 + 1, MAX_SIZE_LOG2 - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       k = 0;
        1:       k = $urandom_range(MAX_PROBES + 1, 15);
        2:       k = MAX_PROBES;
        default: k = $urandom_range(1, MAX_PROBES - 1);
      endcase
      apply_settings(sz, k, $urandom_range(0, 7) != 0);
      repeat (PHASE_WORDS) queue_random_word();
      drain_and_settle();
    end

    $display("%0d words sent (%0d clears) over %0d filter settings, %0d probe answers checked",
             words_accepted, clears_sent, settings_used, answers_checked);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
